@@ hw/rtl/upd_pkg.sv @@
// Shared types, character codes and helper functions for the URL percent decoder.
package upd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int GROUP_BYTES     = 3;

    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UP_A    = 8'h41;
    localparam logic [7:0] CHR_UP_F    = 8'h46;
    localparam logic [7:0] CHR_LO_A    = 8'h61;
    localparam logic [7:0] CHR_LO_F    = 8'h66;

    // One group of up to three output bytes caused by a single input item.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       last;
    } t_group;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Value of a hex digit character; ok is low when the byte is not a digit.
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        logic [7:0] d;
        h.ok  = 1'b0;
        h.val = 4'd0;
        d     = 8'd0;
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            d     = c - CHR_ZERO;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
            d     = c - CHR_UP_A + 8'd10;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (c >= CHR_LO_A && c <= CHR_LO_F) begin
            d     = c - CHR_LO_A + 8'd10;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

endpackage

@@ hw/rtl/upd_front.sv @@
// Front end: accepts raw bytes, tracks the escape state and forms output groups.
module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic            i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output upd_pkg::t_group o_group
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_plus;

    logic           accept;
    logic           p_open;
    logic [7:0]     p_byte;
    upd_pkg::t_hex  hv;
    upd_pkg::t_hex  hi;
    upd_pkg::t_group grp;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        hv     = upd_pkg::hex_value(i_byte);
        hi     = upd_pkg::hex_value(r_held);
        // A percent sign opens an escape unless it is the final byte.
        p_open = (i_byte == upd_pkg::CHR_PERCENT) && !i_last;
        p_byte = (i_byte == upd_pkg::CHR_PLUS && r_plus) ? upd_pkg::CHR_SPACE : i_byte;

        grp.b0   = p_byte;
        grp.b1   = p_byte;
        grp.b2   = p_byte;
        grp.cnt  = {1'b0, !p_open};
        grp.last = i_last;
        n_phase  = p_open ? PH_PCT : PH_IDLE;
        n_held   = r_held;

        case (r_phase)
            PH_PCT: begin
                if (hv.ok) begin
                    if (i_last) begin
                        grp.b0  = upd_pkg::CHR_PERCENT;
                        grp.b1  = i_byte;
                        grp.cnt = 2'd2;
                        n_phase = PH_IDLE;
                    end else begin
                        grp.cnt = 2'd0;
                        n_held  = i_byte;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    grp.b0  = upd_pkg::CHR_PERCENT;
                    grp.b1  = p_byte;
                    grp.cnt = p_open ? 2'd1 : 2'd2;
                end
            end
            PH_DIGIT: begin
                if (hv.ok) begin
                    grp.b0  = {(hi.ok ? hi.val : 4'd0), hv.val};
                    grp.cnt = 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    grp.b0  = upd_pkg::CHR_PERCENT;
                    grp.b1  = r_held;
                    grp.b2  = p_byte;
                    grp.cnt = p_open ? 2'd2 : 2'd3;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push  = accept && (grp.cnt != 2'd0);
    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
            r_plus  <= 1'b1;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end
            if (i_cfg_wr_en) begin
                r_plus <= i_cfg_wr_data;
            end
        end
    end

endmodule

@@ hw/rtl/upd_queue.sv @@
// Short register queue of output groups between front and back end.
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upd_pkg::t_group i_group,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output upd_pkg::t_group o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    upd_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/upd_back.sv @@
// Back end: walks the bytes of the head group into the output register.
module upd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  upd_pkg::t_group i_head,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = !i_q_empty && (!r_valid || i_ready);
    assign at_end = (r_idx + 2'd1 == i_head.cnt);
    assign o_pop  = load && at_end;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= i_head.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

@@ hw/rtl/url_percent_decoder_core.sv @@
// Top level of the URL percent decoder: front end, group queue and back end.
//
//  Channel   Direction  Handshake                  Content
//  s_axis    in         tvalid / tready            tdata = raw byte, tlast = final byte
//  m_axis    out        tvalid / tready            tdata = decoded byte, tlast = final byte
//  cfg       in         wr_en (no wait)            wr_data = plus_to_space
//
// The front end takes one item per cycle whenever the queue has a free slot.
// Each item yields zero to three output bytes, stored as one group in the queue if any;
// the back end sends one byte per cycle while the output is ready, a group byte by byte.
// Output never outnumbers input over a string, so the queue of QUEUE_DEPTH groups keeps
// both sides at one item per cycle while the output is ready; the input stalls only when full.
// Reset is synchronous and active low and sets plus_to_space to 1 with no escape pending.
module url_percent_decoder_core #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration: the single plus_to_space bit.
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    // Input stream.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    // Output stream.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    upd_pkg::t_group push_group;
    upd_pkg::t_group head_group;
    logic push, pop, q_full, q_empty;

    // The front end decides escape handling and packs each item's bytes.
    upd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_q_full      (q_full),
        .o_ready       (o_s_axis_tready),
        .o_push        (push),
        .o_group       (push_group)
    );

    // Items that only hold a byte push nothing, so the queue sees real output only.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_group)
    );

    // The back end serializes the head group through the output register.
    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_group),
        .o_pop     (pop),
        .i_ready   (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

@@ hw/rtl/upd_checker.sv @@
// Port-level checks for the URL percent decoder, bound to the top level.
module upd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // After a reset cycle the output is empty and the input can be taken.
    a_reset_clean: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("outputs not idle after reset");

    // An accepted final byte always produces at least one result on the output.
    a_last_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |-> ##2 o_m_axis_tvalid)
        else $error("final input byte produced no output");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        ($stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output item changed while stalled");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
